>>> hdl/bpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap page allocator.
// Holds the request and response structs and the controller/datapath interface.
// No dependencies.
package bpa_pkg;

	// Bitmap words as stored in the RAM.
	localparam int WORD_W      = 64;
	localparam int OFF_W       = 6;
	localparam int BYTE_W      = 8;
	localparam int BYTE_IDX_W  = 3;

	// Field widths.
	localparam int OPCODE_W    = 2;
	localparam int PAGE_W      = 12;
	localparam int COUNT_W     = 13;
	localparam int STATUS_W    = 2;

	localparam logic [COUNT_W-1:0] TOTAL_RESET = 13'd4096;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_MARK  = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_NO_FIT     = 2'd1,
		STATUS_ZERO_COUNT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN,
		S_WR_RD,
		S_WR_WB
	} state_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [PAGE_W-1:0]   first_page;
		logic [COUNT_W-1:0]  num_pages;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   start_page;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clr_step;
		logic    load;
		logic    scan_begin;
		logic    retry;
		logic    scan_rd;
		logic    scan_step;
		logic    wr_rd;
		logic    wr_wb;
		logic    finish;
		status_t status;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic                zero_count;
		logic                rw;
		logic                clr_last;
		logic                scan_found;
		logic                word_done;
		logic                pass_last;
		logic                from_zero;
		logic                wr_last;
	} dp_stat_t;

endpackage

>>> hdl/bpa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/bpa_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg.
module bpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  bpa_pkg::dp_stat_t    stat,
	output bpa_pkg::ctrl_cmd_t   cmd,
	output logic                 busy
);

	bpa_pkg::state_t state_q;
	bpa_pkg::state_t state_n;
	logic            is_alloc;

	assign is_alloc = (stat.opcode == bpa_pkg::OP_ALLOC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				if (stat.clr_last) begin
					state_n = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_IDLE: begin
				if (start) begin
					state_n = bpa_pkg::S_DECODE;
				end
			end
			bpa_pkg::S_DECODE: begin
				if (is_alloc && !stat.zero_count) begin
					state_n = bpa_pkg::S_SCAN_RD;
				end else if (stat.rw) begin
					state_n = bpa_pkg::S_WR_RD;
				end else begin
					state_n = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_SCAN_RD: begin
				state_n = bpa_pkg::S_SCAN;
			end
			bpa_pkg::S_SCAN: begin
				if (stat.scan_found) begin
					state_n = bpa_pkg::S_WR_RD;
				end else if (stat.word_done) begin
					if (stat.pass_last && stat.from_zero) begin
						state_n = bpa_pkg::S_IDLE;
					end else begin
						state_n = bpa_pkg::S_SCAN_RD;
					end
				end
			end
			bpa_pkg::S_WR_RD: begin
				state_n = bpa_pkg::S_WR_WB;
			end
			bpa_pkg::S_WR_WB: begin
				if (stat.wr_last) begin
					state_n = bpa_pkg::S_IDLE;
				end else begin
					state_n = bpa_pkg::S_WR_RD;
				end
			end
			default: begin
				state_n = bpa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.status = bpa_pkg::STATUS_OK;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			bpa_pkg::S_IDLE: begin
				cmd.load = start;
			end
			bpa_pkg::S_DECODE: begin
				if (is_alloc) begin
					if (stat.zero_count) begin
						cmd.finish = 1'b1;
						cmd.status = bpa_pkg::STATUS_ZERO_COUNT;
					end else begin
						cmd.scan_begin = 1'b1;
					end
				end else if (!stat.rw) begin
					cmd.finish = 1'b1;
				end
			end
			bpa_pkg::S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
			end
			bpa_pkg::S_SCAN: begin
				if (!stat.scan_found && stat.word_done && stat.pass_last) begin
					if (stat.from_zero) begin
						cmd.finish = 1'b1;
						cmd.status = bpa_pkg::STATUS_NO_FIT;
					end else begin
						cmd.retry = 1'b1;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			bpa_pkg::S_WR_RD: begin
				cmd.wr_rd = 1'b1;
			end
			bpa_pkg::S_WR_WB: begin
				cmd.wr_wb  = 1'b1;
				cmd.finish = stat.wr_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != bpa_pkg::S_IDLE);

endmodule

>>> hdl/bpa_datapath.sv
`timescale 1ns / 1ps
// Datapath of the bitmap page allocator: bitmap RAM, run tracker, range writer.
// Depends on bpa_pkg and bpa_ram.
module bpa_datapath #(
	parameter int PAGES = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bpa_pkg::req_t                         req,
	input  bpa_pkg::ctrl_cmd_t                    cmd,
	input  logic                                  cfg_wr,
	input  logic [bpa_pkg::COUNT_W-1:0]           cfg_data,
	output bpa_pkg::dp_stat_t                     stat,
	output logic                                  done,
	output bpa_pkg::rsp_t                         rsp
);

	localparam int WORD_W = bpa_pkg::WORD_W;
	localparam int OFF_W  = bpa_pkg::OFF_W;
	localparam int CNT_W  = bpa_pkg::COUNT_W;
	localparam int DEPTH  = (PAGES + WORD_W - 1) / WORD_W;
	localparam int WAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW     = WAW + OFF_W;
	localparam int CW     = ((PW > 14) ? PW : 14) + 1;

	// Registers.
	logic [CNT_W-1:0]                   total_q;
	logic [WAW-1:0]                     word_q;
	logic [bpa_pkg::BYTE_IDX_W-1:0]     byte_q;
	logic [PW-1:0]                      cursor_q;
	logic                               done_q;
	logic [bpa_pkg::OPCODE_W-1:0]       opcode_q;
	logic [CNT_W-1:0]                   count_q;
	logic                               rw_q;
	logic [PW-1:0]                      lo_q;
	logic [PW-1:0]                      hi_q;
	logic [PW-1:0]                      from_q;
	logic [CNT_W-1:0]                   run_q;
	bpa_pkg::rsp_t                      rsp_q;

	// RAM interface.
	logic                               ram_rd_en;
	logic                               ram_wr_en;
	logic [WORD_W-1:0]                  ram_wr_data;
	logic [WORD_W-1:0]                  ram_rd_data;

	// Limit and request decode.
	logic [CW-1:0]                      lim_c;
	logic [CW-1:0]                      first_c;
	logic [CW-1:0]                      end_c;
	logic [CW-1:0]                      top_c;
	logic [CW-1:0]                      top_m1;
	logic                               rw_n;

	// Scan.
	logic [CW-1:0]                      base_c;
	logic [WORD_W-1:0]                  ge_mask;
	logic [WORD_W-1:0]                  lt_mask;
	logic [WORD_W-1:0]                  eff;
	logic [CNT_W-1:0]                   run_v;
	logic                               fnd_v;
	logic [OFF_W-1:0]                   off_v;
	logic [OFF_W-1:0]                   pos_v;
	logic [CNT_W-1:0]                   need_v;
	logic                               all_free;
	logic                               none_free;
	logic                               fast;
	logic                               fast_found;
	logic                               scan_found;
	logic                               word_done;
	logic [OFF_W-1:0]                   scan_off;
	logic [CNT_W-1:0]                   run_n;
	logic [PW-1:0]                      end_pos;
	logic [PW-1:0]                      lo_n;

	// Range write.
	logic [WAW-1:0]                     lo_word;
	logic [WAW-1:0]                     hi_word;
	logic [WORD_W-1:0]                  lo_mask;
	logic [WORD_W-1:0]                  hi_mask;
	logic [WORD_W-1:0]                  wr_mask;
	logic                               set_bits;

	bpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (word_q),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (word_q),
		.rd_data (ram_rd_data)
	);

	assign lim_c = (CW'(total_q) > CW'(PAGES)) ? CW'(PAGES) : CW'(total_q);

	// Free and mark ranges are clipped to the limit at load time.
	assign first_c = CW'(req.first_page);
	assign end_c   = first_c + CW'(req.num_pages);
	assign top_c   = (end_c < lim_c) ? end_c : lim_c;
	assign top_m1  = top_c - CW'(1);
	assign rw_n    = ((req.opcode == bpa_pkg::OP_FREE) || (req.opcode == bpa_pkg::OP_MARK))
		&& (first_c < top_c);

	// Free bits of the current word that count for this pass.
	assign base_c  = CW'({word_q, {OFF_W{1'b0}}});
	assign ge_mask = (word_q == from_q[PW-1:OFF_W]) ?
		({WORD_W{1'b1}} << from_q[OFF_W-1:0]) : {WORD_W{1'b1}};

	always_comb begin
		if (base_c + CW'(WORD_W) <= lim_c) begin
			lt_mask = {WORD_W{1'b1}};
		end else if (base_c < lim_c) begin
			lt_mask = ~({WORD_W{1'b1}} << lim_c[OFF_W-1:0]);
		end else begin
			lt_mask = '0;
		end
	end

	assign eff = ~ram_rd_data & ge_mask & lt_mask;

	// One byte of the word per cycle through the run counter.
	always_comb begin
		run_v = run_q;
		fnd_v = 1'b0;
		off_v = '0;
		pos_v = '0;
		for (int k = 0; k < bpa_pkg::BYTE_W; k++) begin
			pos_v = {byte_q, bpa_pkg::BYTE_IDX_W'(k)};
			if (!fnd_v) begin
				if (eff[pos_v]) begin
					run_v = run_v + CNT_W'(1);
					if (run_v == count_q) begin
						fnd_v = 1'b1;
						off_v = pos_v;
					end
				end else begin
					run_v = '0;
				end
			end
		end
	end

	// Whole words that are all free or all used are taken at once, without the byte-wise run counter.
	assign need_v     = count_q - run_q;
	assign all_free   = &eff;
	assign none_free  = ~|eff;
	assign fast       = (byte_q == '0) && (all_free || none_free);
	assign fast_found = fast && all_free && (need_v <= CNT_W'(WORD_W));
	assign scan_found = fast ? fast_found : fnd_v;
	assign scan_off   = fast ? OFF_W'(need_v - CNT_W'(1)) : off_v;
	assign word_done  = fast ? !fast_found : ((byte_q == '1) && !fnd_v);
	assign run_n      = fast ? (all_free ? run_q + CNT_W'(WORD_W) : '0) : run_v;
	assign end_pos    = {word_q, scan_off};
	assign lo_n       = end_pos - PW'(count_q) + PW'(1);

	// Read-modify-write masks. 63 - offset is the inverted offset.
	assign lo_word  = lo_q[PW-1:OFF_W];
	assign hi_word  = hi_q[PW-1:OFF_W];
	assign lo_mask  = (word_q == lo_word) ?
		({WORD_W{1'b1}} << lo_q[OFF_W-1:0]) : {WORD_W{1'b1}};
	assign hi_mask  = (word_q == hi_word) ?
		({WORD_W{1'b1}} >> (~hi_q[OFF_W-1:0])) : {WORD_W{1'b1}};
	assign wr_mask  = lo_mask & hi_mask;
	assign set_bits = (opcode_q != bpa_pkg::OP_FREE);

	assign ram_rd_en   = cmd.scan_rd | cmd.wr_rd;
	assign ram_wr_en   = cmd.clr_step | cmd.wr_wb;
	assign ram_wr_data = cmd.clr_step ? {WORD_W{1'b1}} :
		(set_bits ? (ram_rd_data | wr_mask) : (ram_rd_data & ~wr_mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= bpa_pkg::TOTAL_RESET;
			word_q   <= '0;
			byte_q   <= '0;
			cursor_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cfg_wr) begin
				total_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				word_q <= word_q + WAW'(1);
			end else if (cmd.load) begin
				word_q <= first_c[PW-1:OFF_W];
			end else if (cmd.scan_begin) begin
				word_q <= cursor_q[PW-1:OFF_W];
				byte_q <= '0;
			end else if (cmd.retry) begin
				cursor_q <= '0;
				word_q   <= '0;
				byte_q   <= '0;
			end else if (cmd.scan_step) begin
				if (scan_found) begin
					word_q   <= lo_n[PW-1:OFF_W];
					cursor_q <= end_pos;
					byte_q   <= '0;
				end else if (word_done) begin
					word_q <= word_q + WAW'(1);
					byte_q <= '0;
				end else begin
					byte_q <= byte_q + bpa_pkg::BYTE_IDX_W'(1);
				end
			end else if (cmd.wr_wb) begin
				word_q <= word_q + WAW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q <= req.opcode;
			count_q  <= req.num_pages;
			rw_q     <= rw_n;
			lo_q     <= first_c[PW-1:0];
			hi_q     <= top_m1[PW-1:0];
		end
		if (cmd.scan_begin) begin
			from_q <= cursor_q;
			run_q  <= '0;
		end else if (cmd.retry) begin
			from_q <= '0;
			run_q  <= '0;
		end else if (cmd.scan_step) begin
			run_q <= run_n;
			if (scan_found) begin
				lo_q <= lo_n;
				hi_q <= end_pos;
			end
		end
		if (cmd.finish) begin
			rsp_q.status     <= cmd.status;
			rsp_q.start_page <= ((opcode_q == bpa_pkg::OP_ALLOC)
				&& (cmd.status == bpa_pkg::STATUS_OK)) ? bpa_pkg::PAGE_W'(lo_q) : '0;
		end
	end

	assign stat.opcode     = opcode_q;
	assign stat.zero_count = (count_q == '0);
	assign stat.rw         = rw_q;
	assign stat.clr_last   = (word_q == WAW'(DEPTH - 1));
	assign stat.scan_found = scan_found;
	assign stat.word_done  = word_done;
	assign stat.pass_last  = (base_c + CW'(WORD_W) >= lim_c);
	assign stat.from_zero  = (from_q == '0);
	assign stat.wr_last    = (word_q == hi_word);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> hdl/bitmap_page_allocator_core.sv
`timescale 1ns / 1ps
// Top level of the bitmap page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath (and through it bpa_ram).
//
//   Channel   Handshake              Payload               Transaction at
//   -------   ---------------------  --------------------  -----------------------------
//   request   start / busy           req  (bpa_pkg::req_t) clk edge, start && !busy
//   result    done (one-cycle pulse) rsp  (bpa_pkg::rsp_t) clk edge ending the done cycle
//   config    cfg_valid / cfg_ready  cfg_data (total_pages) clk edge, cfg_valid && cfg_ready
//
// After reset the block sweeps the bitmap RAM to all ones, one 64-bit word per
// cycle with busy high; config writes are taken during that sweep. A free or
// mark decodes the request, then reads and writes back each bitmap word touched.
// An allocate decodes the request, then reads each scanned word and takes it
// whole when it is all free or all used, or one byte of the run tracker per cycle
// when it is mixed, again for the retry pass from page 0 when it runs, and then
// reads and writes back each word of the run marked. The registered RAM read and
// the byte-wide run tracker set the pace. The result pulse follows the last cycle
// of work; the receiver cannot stall it, so nothing backs up.
module bitmap_page_allocator_core #(
	parameter int PAGES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  bpa_pkg::req_t                 req,
	output logic                          busy,
	output logic                          done,
	output bpa_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpa_pkg::COUNT_W-1:0]   cfg_data
);

	bpa_pkg::ctrl_cmd_t cmd;
	bpa_pkg::dp_stat_t  stat;
	logic               cfg_wr;

	// The limit register can take a write in any cycle; software must write it only
	// while no request is in flight, which the block itself does not enforce.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// The controller sequences the clearing sweep, the word-by-word scan with
	// its single retry, and the read-modify-write of page ranges.
	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath owns the bitmap RAM, the search cursor, the run counter and
	// the result register.
	bpa_datapath #(
		.PAGES (PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.cfg_wr   (cfg_wr),
		.cfg_data (cfg_data),
		.stat     (stat),
		.done     (done),
		.rsp      (rsp)
	);

`ifndef ASSERT_OFF
	// A result is only ever presented once the controller is back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// Every result closes work that was in flight.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// Only a successful allocation reports a page.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != bpa_pkg::STATUS_OK)) |-> (rsp.start_page == '0))
		else $error("nonzero start page on failed request");
`endif

endmodule
